FILE: rtl/msq_pkg.sv
// Shared types and constants for the max-score selection queue.
`default_nettype none
package msq_pkg;

    localparam int MOVE_W  = 16;
    localparam int SCORE_W = 32;
    localparam int ENTRY_W = MOVE_W + SCORE_W;

    typedef enum logic [1:0] {
        CMD_CLEAR    = 2'd0,
        CMD_INSERT   = 2'd1,
        CMD_PRIORITY = 2'd2,
        CMD_DEQUEUE  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_DRAIN,
        S_SWAP,
        S_FINISH
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch;
        logic clear_q;
        logic push;
        logic flag_full;
        logic set_prio;
        logic pop_prio;
        logic flag_empty;
        logic scan_init;
        logic scan_read;
        logic swap;
        logic load_out;
    } t_ctrl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_cmd cmd;
        logic prio_valid;
        logic empty_q;
        logic full;
        logic scan_end;
        logic out_free;
    } t_ctrl_sts;

endpackage
`default_nettype wire

FILE: rtl/msq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module msq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

FILE: rtl/msq_ctrl.sv
// Controller state machine of the max-score selection queue.
`default_nettype none
module msq_ctrl
    import msq_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_ctrl_sts i_sts,
    output t_ctrl_cmd      o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_FINISH;
                unique case (i_sts.cmd)
                    CMD_CLEAR: begin
                        o_cmd.clear_q = 1'b1;
                    end
                    CMD_INSERT: begin
                        if (i_sts.full) begin
                            o_cmd.flag_full = 1'b1;
                        end else begin
                            o_cmd.push = 1'b1;
                        end
                    end
                    CMD_PRIORITY: begin
                        o_cmd.set_prio = 1'b1;
                    end
                    CMD_DEQUEUE: begin
                        if (i_sts.prio_valid) begin
                            o_cmd.pop_prio = 1'b1;
                        end else if (i_sts.empty_q) begin
                            o_cmd.flag_empty = 1'b1;
                        end else begin
                            o_cmd.scan_init = 1'b1;
                            n_state         = S_SCAN;
                        end
                    end
                    default: begin
                        n_state = S_FINISH;
                    end
                endcase
            end
            S_SCAN: begin
                o_cmd.scan_read = 1'b1;
                if (i_sts.scan_end) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                // The last read's data is compared in this cycle.
                n_state = S_SWAP;
            end
            S_SWAP: begin
                o_cmd.swap = 1'b1;
                n_state    = S_FINISH;
            end
            S_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

FILE: rtl/msq_dp.sv
// Datapath of the max-score selection queue: entry store, scan and output register.
`default_nettype none
module msq_dp
    import msq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 256
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic [1:0]                i_command,
    input  wire logic [MOVE_W-1:0]         i_move_code,
    input  wire logic signed [SCORE_W-1:0] i_move_score,
    input  wire logic                      i_out_ready,
    input  wire t_ctrl_cmd                 i_cmd,
    output t_ctrl_sts                      o_sts,
    output logic                           o_out_valid_hs,
    output logic [MOVE_W-1:0]              o_out_move,
    output logic                           o_out_valid,
    output logic                           o_now_empty,
    output logic [1:0]                     o_status
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    // Latched item.
    t_cmd                r_cmd;
    logic [MOVE_W-1:0]   r_code;
    logic [SCORE_W-1:0]  r_score;

    // Queue state.
    logic [CW-1:0]       r_count;
    logic [MOVE_W-1:0]   r_prio_move;
    logic                r_prio_valid;

    // Scan state.
    logic [AW-1:0]       r_rd_addr;
    logic                r_cmp_valid;
    logic                r_cmp_first;
    logic [AW-1:0]       r_cmp_idx;
    logic [AW-1:0]       r_best_idx;
    logic [MOVE_W-1:0]   r_best_move;
    logic [SCORE_W-1:0]  r_best_score;
    logic [MOVE_W-1:0]   r_last_move;
    logic [SCORE_W-1:0]  r_last_score;

    // Result of the current item and the output register.
    logic [MOVE_W-1:0]   r_res_move;
    logic                r_res_ok;
    t_status             r_res_status;
    logic                r_o_valid;
    logic [MOVE_W-1:0]   r_o_move;
    logic                r_o_ok;
    logic                r_o_empty;
    t_status             r_o_status;

    logic [CW-1:0]       count_m1;
    logic [AW-1:0]       last_idx;
    logic                out_free;
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [ENTRY_W-1:0]  ram_wdata;
    logic [ENTRY_W-1:0]  ram_rdata;
    logic [MOVE_W-1:0]   rd_move;
    logic [SCORE_W-1:0]  rd_score;
    logic                rd_better;

    assign count_m1 = r_count - CW'(1);
    assign last_idx = count_m1[AW-1:0];
    assign out_free = !r_o_valid || i_out_ready;

    // Status towards the controller.
    always_comb begin
        o_sts.cmd        = r_cmd;
        o_sts.prio_valid = r_prio_valid;
        o_sts.empty_q    = (r_count == '0);
        o_sts.full       = (r_count == CW'(QUEUE_DEPTH));
        o_sts.scan_end   = (r_rd_addr == last_idx);
        o_sts.out_free   = out_free;
    end

    // Entry store: an insert writes at the fill count, a swap moves the last entry.
    assign ram_we    = i_cmd.push || i_cmd.swap;
    assign ram_waddr = i_cmd.swap ? r_best_idx : r_count[AW-1:0];
    assign ram_wdata = i_cmd.swap ? {r_last_move, r_last_score} : {r_code, r_score};

    msq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (i_cmd.scan_read),
        .i_raddr (r_rd_addr),
        .o_rdata (ram_rdata)
    );

    assign rd_move   = ram_rdata[ENTRY_W-1:SCORE_W];
    assign rd_score  = ram_rdata[SCORE_W-1:0];
    assign rd_better = $signed(rd_score) > $signed(r_best_score);

    // Latch the accepted item.
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_cmd   <= t_cmd'(i_command);
            r_code  <= i_move_code;
            r_score <= i_move_score;
        end
    end

    // Fill count and priority slot.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_prio_valid <= 1'b0;
        end else begin
            if (i_cmd.clear_q) begin
                r_count      <= '0;
                r_prio_valid <= 1'b0;
            end
            if (i_cmd.push) begin
                r_count <= r_count + CW'(1);
            end
            if (i_cmd.swap) begin
                r_count <= count_m1;
            end
            if (i_cmd.set_prio) begin
                r_prio_valid <= 1'b1;
            end
            if (i_cmd.pop_prio) begin
                r_prio_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.set_prio) begin
            r_prio_move <= r_code;
        end
    end

    // Scan address and compare pipeline flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_valid <= 1'b0;
        end else begin
            r_cmp_valid <= i_cmd.scan_read;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_init) begin
            r_rd_addr <= '0;
        end else if (i_cmd.scan_read) begin
            r_rd_addr <= r_rd_addr + AW'(1);
        end
        r_cmp_first <= (r_rd_addr == '0);
        r_cmp_idx   <= r_rd_addr;
    end

    // Running maximum; ties keep the earlier entry. The last entry read is kept too.
    always_ff @(posedge i_clk) begin
        if (r_cmp_valid) begin
            r_last_move  <= rd_move;
            r_last_score <= rd_score;
            if (r_cmp_first || rd_better) begin
                r_best_idx   <= r_cmp_idx;
                r_best_move  <= rd_move;
                r_best_score <= rd_score;
            end
        end
    end

    // Result of the item in progress.
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_res_move   <= '0;
            r_res_ok     <= 1'b0;
            r_res_status <= ST_OK;
        end
        if (i_cmd.flag_full) begin
            r_res_status <= ST_FULL;
        end
        if (i_cmd.flag_empty) begin
            r_res_status <= ST_EMPTY;
        end
        if (i_cmd.pop_prio) begin
            r_res_move <= r_prio_move;
            r_res_ok   <= 1'b1;
        end
        if (i_cmd.swap) begin
            r_res_move <= r_best_move;
            r_res_ok   <= 1'b1;
        end
    end

    // Output register: holds a finished item until the consumer takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_o_move   <= r_res_move;
            r_o_ok     <= r_res_ok;
            r_o_status <= r_res_status;
            r_o_empty  <= !r_prio_valid && (r_count == '0);
        end
    end

    assign o_out_valid_hs = r_o_valid;
    assign o_out_move     = r_o_move;
    assign o_out_valid    = r_o_ok;
    assign o_now_empty    = r_o_empty;
    assign o_status       = r_o_status;

endmodule
`default_nettype wire

FILE: rtl/max_score_select_queue.sv
// Top level of the max-score selection queue.
//
// A queue of (move, score) entries with one priority slot. Clear, insert and
// set-priority items pass through the execute and finish states to a result
// in the output register, as does a dequeue served from the priority slot or
// refused on an empty queue. A dequeue from the stored entries reads the entry
// memory once per stored entry through its single read port, then passes a
// drain state that compares the last read, a swap state that moves the last
// entry into the winner's place and the finish state that loads the result.
// The entry memory needs no clearing after reset: only entries below the fill
// count are ever read. A new item is taken once the previous one has reached
// the output register, even if that result has not yet been taken.
`default_nettype none
module max_score_select_queue
    import msq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 256
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_ready,
    input  wire logic [1:0]                i_command,
    input  wire logic [MOVE_W-1:0]         i_move_code,
    input  wire logic signed [SCORE_W-1:0] i_move_score,
    output logic                           o_valid,
    input  wire logic                      i_ready,
    output logic [MOVE_W-1:0]              o_out_move,
    output logic                           o_out_valid,
    output logic                           o_now_empty,
    output logic [1:0]                     o_status
);

    t_ctrl_cmd ctrl_cmd;
    t_ctrl_sts ctrl_sts;

    msq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_valid),
        .o_in_ready (o_ready),
        .i_sts      (ctrl_sts),
        .o_cmd      (ctrl_cmd)
    );

    msq_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_command      (i_command),
        .i_move_code    (i_move_code),
        .i_move_score   (i_move_score),
        .i_out_ready    (i_ready),
        .i_cmd          (ctrl_cmd),
        .o_sts          (ctrl_sts),
        .o_out_valid_hs (o_valid),
        .o_out_move     (o_out_move),
        .o_out_valid    (o_out_valid),
        .o_now_empty    (o_now_empty),
        .o_status       (o_status)
    );

endmodule
`default_nettype wire

FILE: rtl/max_score_select_queue_chk.sv
// Port-level checker for the max-score selection queue, with its bind.
`default_nettype none
module max_score_select_queue_chk
    import msq_pkg::*;
(
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      o_valid,
    input wire logic                      i_ready,
    input wire logic [MOVE_W-1:0]         o_out_move,
    input wire logic                      o_out_valid,
    input wire logic                      o_now_empty,
    input wire logic [1:0]                o_status
);

    // A result without a dequeued move carries a zero move word.
    a_move_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_out_valid) |-> (o_out_move == '0))
        else $error("move word not zero without a dequeued move");

    // A dequeued move always comes with an ok status.
    a_move_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out_valid) |-> (o_status == 2'(ST_OK)))
        else $error("dequeued move with an error status");

    // A refused insert means the queue is full, so it cannot be empty.
    a_full_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == 2'(ST_FULL)) |-> !o_now_empty)
        else $error("full status reported with an empty queue");

    // A refused dequeue leaves the queue empty.
    a_empty_stays: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == 2'(ST_EMPTY)) |-> (o_now_empty && !o_out_valid))
        else $error("empty status reported with a non-empty queue");

    // A stalled result item holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_out_move) && $stable(o_status)))
        else $error("stalled result item changed");

endmodule

bind max_score_select_queue max_score_select_queue_chk u_chk (.*);
`default_nettype wire

FILE: sim/tb_max_score_select_queue.sv
// Self-checking testbench for the max-score selection queue.
`default_nettype none
module tb_max_score_select_queue;
    import msq_pkg::*;

    localparam int DEPTH        = 256;
    localparam int RANDOM_ITEMS = 1950;
    localparam int HOLD_CYCLES  = 400;
    localparam int SETTLE       = 300;

    // One result item as the block presents it.
    typedef struct packed {
        logic [MOVE_W-1:0] move;
        logic              out_valid;
        logic              now_empty;
        t_status           status;
    } t_result;

    // One row of the directed stimulus table.
    typedef struct packed {
        t_cmd               cmd;
        logic [MOVE_W-1:0]  code;
        logic [SCORE_W-1:0] score;
        logic               typed;
        t_result            res;
    } t_row;

    localparam t_result UNTYPED = '{move: '0, out_valid: 1'b0, now_empty: 1'b0, status: ST_OK};

    // Rows with a typed result are checked against it; the rest follow the predictor.
    localparam t_row DIRECTED [24] = '{
        '{CMD_DEQUEUE,  16'h0000, 32'h0000_0000, 1'b1, '{16'h0000, 1'b0, 1'b1, ST_EMPTY}},
        '{CMD_CLEAR,    16'hFFFF, 32'hFFFF_FFFF, 1'b1, '{16'h0000, 1'b0, 1'b1, ST_OK}},
        '{CMD_INSERT,   16'hFFFF, 32'h8000_0000, 1'b1, '{16'h0000, 1'b0, 1'b0, ST_OK}},
        '{CMD_DEQUEUE,  16'h0000, 32'h0000_0000, 1'b1, '{16'hFFFF, 1'b1, 1'b1, ST_OK}},
        '{CMD_INSERT,   16'h0000, 32'h7FFF_FFFF, 1'b0, UNTYPED},
        '{CMD_INSERT,   16'h1234, 32'h8000_0000, 1'b0, UNTYPED},
        '{CMD_INSERT,   16'hAAAA, 32'h7FFF_FFFF, 1'b0, UNTYPED},
        '{CMD_INSERT,   16'h5555, 32'h0000_0000, 1'b0, UNTYPED},
        '{CMD_INSERT,   16'h8001, 32'hFFFF_FFFF, 1'b0, UNTYPED},
        '{CMD_PRIORITY, 16'hBEEF, 32'h0000_0000, 1'b0, UNTYPED},
        '{CMD_PRIORITY, 16'h5A5A, 32'hFFFF_FFFF, 1'b0, UNTYPED},
        '{CMD_DEQUEUE,  16'hFFFF, 32'h1234_5678, 1'b0, UNTYPED},
        '{CMD_DEQUEUE,  16'h0000, 32'h0000_0000, 1'b0, UNTYPED},
        '{CMD_DEQUEUE,  16'h0000, 32'h0000_0000, 1'b0, UNTYPED},
        '{CMD_DEQUEUE,  16'h0000, 32'h0000_0000, 1'b0, UNTYPED},
        '{CMD_DEQUEUE,  16'h0000, 32'h0000_0000, 1'b0, UNTYPED},
        '{CMD_DEQUEUE,  16'h0000, 32'h0000_0000, 1'b0, UNTYPED},
        '{CMD_DEQUEUE,  16'h0000, 32'h0000_0000, 1'b1, '{16'h0000, 1'b0, 1'b1, ST_EMPTY}},
        '{CMD_PRIORITY, 16'hFFFF, 32'h0000_0000, 1'b0, UNTYPED},
        '{CMD_INSERT,   16'h7FFF, 32'h1234_5678, 1'b0, UNTYPED},
        '{CMD_CLEAR,    16'h0000, 32'h0000_0000, 1'b1, '{16'h0000, 1'b0, 1'b1, ST_OK}},
        '{CMD_DEQUEUE,  16'h0000, 32'h0000_0000, 1'b1, '{16'h0000, 1'b0, 1'b1, ST_EMPTY}},
        '{CMD_PRIORITY, 16'h0000, 32'h0000_0000, 1'b0, UNTYPED},
        '{CMD_DEQUEUE,  16'h0000, 32'h0000_0000, 1'b1, '{16'h0000, 1'b1, 1'b1, ST_OK}}
    };

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      i_valid;
    logic                      o_ready;
    logic [1:0]                i_command;
    logic [MOVE_W-1:0]         i_move_code;
    logic signed [SCORE_W-1:0] i_move_score;
    logic                      o_valid;
    logic                      i_ready;
    logic [MOVE_W-1:0]         o_out_move;
    logic                      o_out_valid;
    logic                      o_now_empty;
    logic [1:0]                o_status;

    // Predicted queue contents and priority slot.
    logic [MOVE_W-1:0]         stored_moves [DEPTH];
    logic signed [SCORE_W-1:0] stored_scores [DEPTH];
    int                        stored_count = 0;
    logic [MOVE_W-1:0]         slot_move = '0;
    logic                      slot_held = 1'b0;

    t_result pending_results [$];
    t_result want_res;
    int      mismatches = 0;
    int      burst_left = 0;
    bit      hold_request = 1'b0;

    max_score_select_queue #(
        .QUEUE_DEPTH (DEPTH)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_command    (i_command),
        .i_move_code  (i_move_code),
        .i_move_score (i_move_score),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_out_move   (o_out_move),
        .o_out_valid  (o_out_valid),
        .o_now_empty  (o_now_empty),
        .o_status     (o_status)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Applies one command to the predicted state and returns the result it gives.
    function automatic t_result predict_queue_step(input t_cmd cmd, input logic [MOVE_W-1:0] code,
                                                   input logic signed [SCORE_W-1:0] score);
        t_result r;
        int      best;
        int      i;
        r = UNTYPED;
        case (cmd)
            CMD_CLEAR: begin
                stored_count = 0;
                slot_held = 1'b0;
            end
            CMD_INSERT: begin
                if (stored_count >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    stored_moves[stored_count] = code;
                    stored_scores[stored_count] = score;
                    stored_count++;
                end
            end
            CMD_PRIORITY: begin
                slot_move = code;
                slot_held = 1'b1;
            end
            default: begin
                if (slot_held) begin
                    r.move = slot_move;
                    r.out_valid = 1'b1;
                    slot_held = 1'b0;
                end else if (stored_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    // The first entry with the highest score wins; the last entry fills its place.
                    best = 0;
                    for (i = 1; i < stored_count; i++) begin
                        if (stored_scores[i] > stored_scores[best]) best = i;
                    end
                    r.move = stored_moves[best];
                    r.out_valid = 1'b1;
                    stored_moves[best] = stored_moves[stored_count-1];
                    stored_scores[best] = stored_scores[stored_count-1];
                    stored_count--;
                end
            end
        endcase
        r.now_empty = !slot_held && (stored_count == 0);
        return r;
    endfunction

    // Scores lean towards the extremes and towards a narrow band that forces ties.
    function automatic logic signed [SCORE_W-1:0] pick_score();
        case ($urandom_range(0, 9))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7FFF_FFFF;
            2, 3, 4: return $urandom_range(0, 6) - 3;
            default: return $urandom();
        endcase
    endfunction

    // Offers one item in bursts with random gaps, then records what it should produce.
    task automatic offer(input t_cmd cmd, input logic [MOVE_W-1:0] code,
                         input logic signed [SCORE_W-1:0] score,
                         input logic typed, input t_result typed_res);
        t_result res;
        int      gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        i_valid      <= 1'b1;
        i_command    <= cmd;
        i_move_code  <= code;
        i_move_score <= score;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        res = predict_queue_step(cmd, code, score);
        pending_results.insert(pending_results.size(), typed ? typed_res : res);
        @(negedge i_clk);
    endtask

    // Stops offering until every outstanding result has been taken.
    task automatic wait_all_results();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (pending_results.size() != 0);
    endtask

    // Receiver: ready patterns change every so often, with one long hold-off on request.
    initial begin
        int mode;
        int mode_left;
        int hold_left;
        mode_left = 0;
        hold_left = 0;
        mode = 0;
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (mode_left == 0) begin
                mode = $urandom_range(0, 2);
                mode_left = $urandom_range(16, 160);
            end
            mode_left--;
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                case (mode)
                    0:       i_ready <= 1'b1;
                    1:       i_ready <= ($urandom_range(0, 3) != 0);
                    default: i_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Each result item taken is compared with the oldest prediction, field by field.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                $display("%0t: result item expected none, actual move %h",
                         $time, o_out_move);
            end else begin
                want_res = pending_results.pop_front();
                if (o_out_move !== want_res.move) begin
                    mismatches++;
                    $display("%0t: out_move expected %h, actual %h",
                             $time, want_res.move, o_out_move);
                end
                if (o_out_valid !== want_res.out_valid) begin
                    mismatches++;
                    $display("%0t: out_valid expected %b, actual %b",
                             $time, want_res.out_valid, o_out_valid);
                end
                if (o_now_empty !== want_res.now_empty) begin
                    mismatches++;
                    $display("%0t: now_empty expected %b, actual %b",
                             $time, want_res.now_empty, o_now_empty);
                end
                if (o_status !== want_res.status) begin
                    mismatches++;
                    $display("%0t: status expected %0d, actual %0d",
                             $time, want_res.status, o_status);
                end
            end
        end
    end

    // Main stimulus: directed table, a long receiver hold-off, then random episodes.
    initial begin
        int sent;
        int episode;
        int fill_target;
        int k;
        sent = 0;
        episode = 0;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_command    = CMD_CLEAR;
        i_move_code  = '0;
        i_move_score = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (DIRECTED[r])
            offer(DIRECTED[r].cmd, DIRECTED[r].code, DIRECTED[r].score,
                  DIRECTED[r].typed, DIRECTED[r].res);

        // The receiver holds off while items keep coming, so the input side has to stall.
        hold_request = 1'b1;
        repeat (8) begin
            offer(t_cmd'($urandom_range(0, 3)), MOVE_W'($urandom()), pick_score(), 1'b0,
                  UNTYPED);
            sent++;
        end
        wait_all_results();

        while (sent < RANDOM_ITEMS) begin
            episode++;
            if (episode == 3 || episode == 20)
                fill_target = DEPTH + $urandom_range(1, 3);
            else if ($urandom_range(0, 4) == 0)
                fill_target = $urandom_range(13, 40);
            else
                fill_target = $urandom_range(1, 12);

            if (fill_target <= DEPTH && $urandom_range(0, 4) == 0) begin
                // Noise: any command with any payload.
                repeat ($urandom_range(8, 24)) begin
                    offer(t_cmd'($urandom_range(0, 3)), MOVE_W'($urandom()), pick_score(),
                          1'b0, UNTYPED);
                    sent++;
                end
            end else begin
                // Well-formed episode: fill the queue, then drain it and dequeue once more.
                if ($urandom_range(0, 1) == 0) begin
                    offer(CMD_CLEAR, MOVE_W'($urandom()), $urandom(), 1'b0, UNTYPED);
                    sent++;
                end
                for (k = 0; k < fill_target; k++) begin
                    if ($urandom_range(0, 9) == 0) begin
                        offer(CMD_PRIORITY, MOVE_W'($urandom()), $urandom(), 1'b0, UNTYPED);
                        sent++;
                    end
                    offer(CMD_INSERT, MOVE_W'($urandom()), pick_score(), 1'b0, UNTYPED);
                    sent++;
                end
                while (slot_held || stored_count != 0) begin
                    case ($urandom_range(0, 39))
                        0:       offer(CMD_CLEAR, MOVE_W'($urandom()), $urandom(), 1'b0,
                                       UNTYPED);
                        1, 2:    offer(CMD_INSERT, MOVE_W'($urandom()), pick_score(), 1'b0,
                                       UNTYPED);
                        3:       offer(CMD_PRIORITY, MOVE_W'($urandom()), $urandom(), 1'b0,
                                       UNTYPED);
                        default: offer(CMD_DEQUEUE, MOVE_W'($urandom()), $urandom(), 1'b0,
                                       UNTYPED);
                    endcase
                    sent++;
                end
                offer(CMD_DEQUEUE, MOVE_W'($urandom()), $urandom(), 1'b0, UNTYPED);
                sent++;
            end
            if ($urandom_range(0, 9) == 0) wait_all_results();
        end
        i_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Watchdog well beyond the slowest correct run.
    initial begin
        #40_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
`default_nettype wire
